// ----- rtl/core/esm_pkg.sv -----
// Shared types and constants for the Eytzinger set membership block.
`default_nettype none
package esm_pkg;
  localparam int unsigned CapacityDefault   = 1024;
  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned CountWidth        = 11;
  localparam int unsigned FieldWidth        = 32;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_LOAD    = 2'd1,
    OP_QUERY   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_RESTART = 2'd0,
    ST_LOADED  = 2'd1,
    ST_ANSWER  = 2'd2,
    ST_REJECT  = 2'd3
  } status_e;

  typedef struct packed {
    logic valid;
    logic active;
    logic found;
  } tok_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/esm_cell.sv -----
// One tree level: node storage for the level and one compare-and-descend step.
`default_nettype none
module esm_cell
  import esm_pkg::*;
#(
  parameter int unsigned LEVEL       = 0,
  parameter int unsigned CAPACITY    = CapacityDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault,
  parameter int unsigned IDX_WIDTH   = $clog2(CapacityDefault + 1) + 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [IDX_WIDTH-1:0]   n_i,
  input  tok_ctl_t              ctl_i,
  input  wire [IDX_WIDTH-1:0]   idx_i,
  input  wire [VALUE_WIDTH-1:0] key_i,
  input  wire                   wr_en_i,
  input  wire [IDX_WIDTH-1:0]   wr_idx_i,
  input  wire [VALUE_WIDTH-1:0] wr_data_i,
  output tok_ctl_t              ctl_o,
  output logic [IDX_WIDTH-1:0]  idx_o,
  output logic [VALUE_WIDTH-1:0] key_o
);
  localparam int unsigned BASE  = 1 << LEVEL;
  localparam int unsigned SPAN  = CAPACITY + 1 - BASE;
  localparam int unsigned DEPTH = (BASE < SPAN) ? BASE : SPAN;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [IDX_WIDTH-1:0]   idx_q;
  tok_ctl_t               ctl_q;
  logic [IDX_WIDTH-1:0]   lvl_bit;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   wr_hit;
  logic                   rd_en;
  logic [IDX_WIDTH-1:0]   nxt_idx;

  assign lvl_bit = IDX_WIDTH'(BASE);
  assign rd_addr = AW'(idx_i ^ lvl_bit);
  assign wr_addr = AW'(wr_idx_i ^ lvl_bit);
  assign wr_hit  = wr_en_i && ((wr_idx_i >> LEVEL) == IDX_WIDTH'(1));
  assign rd_en   = ctl_i.valid && ctl_i.active && !ctl_i.found;

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    idx_q <= idx_i;
    key_q <= key_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_comb begin
    nxt_idx = {idx_q[IDX_WIDTH-2:0], !(rdata_q > key_q)};
    ctl_o   = ctl_q;
    idx_o   = idx_q;
    key_o   = key_q;
    if (ctl_q.active && !ctl_q.found) begin
      if (rdata_q == key_q) begin
        ctl_o.found  = 1'b1;
        ctl_o.active = 1'b0;
      end else begin
        idx_o        = nxt_idx;
        ctl_o.active = (nxt_idx <= n_i);
      end
    end else begin
      ctl_o.active = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/eytzinger_set_membership.sv -----
// Top level: command control, fill walker and the row of tree level cells.
//
//   channel   direction  handshake               payload
//   command   in         start_i, busy_o         operation_i, value_i
//   result    out        done_o (1-cycle strobe) found_o, status_o
//   config    in         cfg_we_i                cfg_wdata_i (element_count)
//
// Query: the key descends through the cell row, one tree level per cell, LEVELS = clog2(CAPACITY+1).
// Load: after each write the fill index moves on to its in-order successor.
// Restart: the fill index descends to the leftmost node (leftmost descent).
// Reset clears control only; node storage is undefined until loaded.
// Results cannot be stalled; busy_o stays high until the done_o strobe.
`default_nettype none
module eytzinger_set_membership
  import esm_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire [1:0]             operation_i,
  input  wire [FieldWidth-1:0]  value_i,
  input  wire                   cfg_we_i,
  input  wire [CountWidth-1:0]  cfg_wdata_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [1:0]            status_o
);
  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
  localparam int unsigned IW     = LEVELS + 1;

  typedef enum logic [2:0] {S_IDLE, S_DESC, S_UP, S_QWAIT, S_FINISH} state_e;

  state_e                 state_q;
  logic [CountWidth-1:0]  count_q;
  logic [CountWidth-1:0]  loaded_q;
  logic [IW-1:0]          fill_q;
  status_e                res_q;
  logic                   done_q;
  logic                   found_q;
  status_e                status_q;

  logic [IW-1:0]          n;
  logic [VALUE_WIDTH-1:0] key;
  logic                   accept;
  logic                   load_ok;
  logic                   query_ok;
  logic [IW-1:0]          fill_dbl;
  logic [IW-1:0]          fill_rgt;

  tok_ctl_t               ctl_w [LEVELS+1];
  logic [IW-1:0]          idx_w [LEVELS+1];
  logic [VALUE_WIDTH-1:0] key_w [LEVELS+1];

  assign n        = (32'(count_q) > CAPACITY) ? IW'(CAPACITY) : IW'(count_q);
  assign key      = VALUE_WIDTH'(value_i);
  assign accept   = start_i && (state_q == S_IDLE);
  assign load_ok  = (32'(loaded_q) < 32'(n)) && (fill_q != '0);
  assign query_ok = (32'(loaded_q) == 32'(n));
  assign fill_dbl = {fill_q[IW-2:0], 1'b0};
  assign fill_rgt = {fill_q[IW-2:0], 1'b1};

  assign ctl_w[0].valid  = accept && (op_e'(operation_i) == OP_QUERY) && query_ok;
  assign ctl_w[0].active = (n != '0);
  assign ctl_w[0].found  = 1'b0;
  assign idx_w[0]        = IW'(1);
  assign key_w[0]        = key;

  for (genvar l = 0; l < LEVELS; l++) begin : g_cell
    esm_cell #(
      .LEVEL      (l),
      .CAPACITY   (CAPACITY),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_WIDTH  (IW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .n_i      (n),
      .ctl_i    (ctl_w[l]),
      .idx_i    (idx_w[l]),
      .key_i    (key_w[l]),
      .wr_en_i  (accept && (op_e'(operation_i) == OP_LOAD) && load_ok),
      .wr_idx_i (fill_q),
      .wr_data_i(key),
      .ctl_o    (ctl_w[l+1]),
      .idx_o    (idx_w[l+1]),
      .key_o    (key_w[l+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= '0;
      fill_q   <= '0;
      res_q    <= ST_REJECT;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= ST_RESTART;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_e'(operation_i))
              OP_RESTART: begin
                loaded_q <= '0;
                res_q    <= ST_RESTART;
                if (n != '0) begin
                  fill_q  <= IW'(1);
                  state_q <= S_DESC;
                end else begin
                  fill_q  <= '0;
                  state_q <= S_FINISH;
                end
              end
              OP_LOAD: begin
                if (load_ok) begin
                  loaded_q <= loaded_q + CountWidth'(1);
                  res_q    <= ST_LOADED;
                  if (fill_rgt <= n) begin
                    fill_q  <= fill_rgt;
                    state_q <= S_DESC;
                  end else begin
                    state_q <= S_UP;
                  end
                end else begin
                  res_q   <= ST_REJECT;
                  state_q <= S_FINISH;
                end
              end
              OP_QUERY: begin
                if (query_ok) begin
                  state_q <= S_QWAIT;
                end else begin
                  res_q   <= ST_REJECT;
                  state_q <= S_FINISH;
                end
              end
              default: begin
                res_q   <= ST_REJECT;
                state_q <= S_FINISH;
              end
            endcase
          end
        end
        S_DESC: begin
          if (fill_dbl <= n) begin
            fill_q <= fill_dbl;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_UP: begin
          fill_q <= fill_q >> 1;
          if (!fill_q[0]) begin
            state_q <= S_FINISH;
          end
        end
        S_QWAIT: begin
          if (ctl_w[LEVELS].valid) begin
            done_q   <= 1'b1;
            found_q  <= ctl_w[LEVELS].found;
            status_q <= ST_ANSWER;
            state_q  <= S_IDLE;
          end
        end
        S_FINISH: begin
          done_q   <= 1'b1;
          found_q  <= 1'b0;
          status_q <= res_q;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign found_o  = found_q;
  assign status_o = status_q;
endmodule
`default_nettype wire

// ----- rtl/core/esm_checker.sv -----
// Port-level checker for the Eytzinger set membership block, with its bind.
`default_nettype none
module esm_checker
  import esm_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start_i,
  input wire       busy_o,
  input wire       done_o,
  input wire       found_o,
  input wire [1:0] status_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  a_found_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == ST_ANSWER))
    else $error("found set on a non-query result");
endmodule

bind eytzinger_set_membership esm_checker u_esm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .found_o (found_o),
  .status_o(status_o)
);
`default_nettype wire
